// ===== sv/wbss_pkg.sv =====
`timescale 1ns / 1ps
package wbss_pkg;

   localparam int SampleW  = 18;
   localparam int GainW    = 16;
   localparam int ProdW    = SampleW + GainW + 1;
   localparam int QuoBits  = 24;
   localparam int DenW     = 35;
   localparam int RemW     = 58;
   localparam int ShW      = $clog2(QuoBits);
   localparam int Latency  = QuoBits + 3;
   localparam int CsrIdxW  = 8;
   localparam int CsrDataW = 16;

   localparam longint KneeQ28   = 64'd241591910;
   localparam longint HeadQ28   = 64'd26843546;
   localparam longint RoundHalf = 64'd8192;
   localparam int     GainReset = 16384;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BYPASS     = 8'd0,
      CSR_RED_GAIN   = 8'd1,
      CSR_GREEN_GAIN = 8'd2,
      CSR_BLUE_GAIN  = 8'd3
   } csr_idx_type;

   // one beat moving through the divider stages of a lane
   typedef struct packed {
      logic [RemW-1:0]    rem;
      logic [DenW-1:0]    den;
      logic [QuoBits-1:0] quo;
      logic               knee;
      logic [SampleW-1:0] early;
   } div_beat_type;

endpackage

// ===== sv/white_balance_soft_shoulder_top.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per clock; busy never rises, three channel lanes
// each run a 24-stage pipelined divider for the highlight shoulder.
// Reset: synchronous; clears the pipeline valids and loads bypass=1, gains=1.0.
// The receiver cannot stall: each result shows for one cycle under rsp_valid.
module white_balance_soft_shoulder_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [wbss_pkg::SampleW-1:0]    req_red_in,
   input  logic signed [wbss_pkg::SampleW-1:0]    req_green_in,
   input  logic signed [wbss_pkg::SampleW-1:0]    req_blue_in,
   output logic                                   rsp_valid,
   output logic signed [wbss_pkg::SampleW-1:0]    rsp_red_out,
   output logic signed [wbss_pkg::SampleW-1:0]    rsp_green_out,
   output logic signed [wbss_pkg::SampleW-1:0]    rsp_blue_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wbss_pkg::CsrIdxW-1:0]           csr_index,
   input  logic [wbss_pkg::CsrDataW-1:0]          csr_wdata
);

   localparam int L = wbss_pkg::Latency;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   logic                       bypass_ff;
   logic [wbss_pkg::GainW-1:0] rgain_ff, ggain_ff, bgain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b1;
         rgain_ff  <= wbss_pkg::GainW'(wbss_pkg::GainReset);
         ggain_ff  <= wbss_pkg::GainW'(wbss_pkg::GainReset);
         bgain_ff  <= wbss_pkg::GainW'(wbss_pkg::GainReset);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wbss_pkg::CSR_BYPASS:     bypass_ff <= csr_wdata[0];
            wbss_pkg::CSR_RED_GAIN:   rgain_ff  <= csr_wdata;
            wbss_pkg::CSR_GREEN_GAIN: ggain_ff  <= csr_wdata;
            wbss_pkg::CSR_BLUE_GAIN:  bgain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // beat valid and bypass tag travel alongside the lanes
   logic [L-1:0] vld_ff, vld_in;
   logic [L-1:0] byp_ff;

   assign vld_in = {vld_ff[L-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else
         vld_ff <= vld_in;
      byp_ff <= {byp_ff[L-2:0], bypass_ff};
   end

   wbss_lane u_red (
      .clock (clock), .bypass (bypass_ff), .gain (rgain_ff),
      .sample (req_red_in), .result (rsp_red_out)
   );
   wbss_lane u_green (
      .clock (clock), .bypass (bypass_ff), .gain (ggain_ff),
      .sample (req_green_in), .result (rsp_green_out)
   );
   wbss_lane u_blue (
      .clock (clock), .bypass (bypass_ff), .gain (bgain_ff),
      .sample (req_blue_in), .result (rsp_blue_out)
   );

   assign rsp_valid = vld_ff[L-1];

   // checks
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, L))
      else $error("result without matching accepted pixel");

   a_after_reset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(reset))
      else $error("result right after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byp_ff[L-1] |->
         rsp_red_out >= 0 && rsp_red_out <= 15565 &&
         rsp_green_out >= 0 && rsp_green_out <= 15565 &&
         rsp_blue_out >= 0 && rsp_blue_out <= 15565)
      else $error("balanced sample out of range");

endmodule

// ===== sv/wbss_div_stage.sv =====
`timescale 1ns / 1ps
// One restoring step: tries divisor << sh against the running remainder.
module wbss_div_stage (
   input  logic                           clock,
   input  logic [wbss_pkg::ShW-1:0]       sh,
   input  wbss_pkg::div_beat_type         beat_in,
   output wbss_pkg::div_beat_type         beat_out
);

   wbss_pkg::div_beat_type        beat_ff;
   wbss_pkg::div_beat_type        beat_in_nxt;
   logic [wbss_pkg::RemW-1:0]     trial;

   always_comb begin
      beat_in_nxt = beat_in;
      trial = wbss_pkg::RemW'(beat_in.den) << sh;
      if (beat_in.rem >= trial) begin
         beat_in_nxt.rem     = beat_in.rem - trial;
         beat_in_nxt.quo[sh] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in_nxt;
   end

   assign beat_out = beat_ff;

endmodule

// ===== sv/wbss_lane.sv =====
`timescale 1ns / 1ps
// One color channel: gain multiply, shoulder setup, pipelined divide, rounding.
module wbss_lane (
   input  logic                                 clock,
   input  logic                                 bypass,
   input  logic [wbss_pkg::GainW-1:0]           gain,
   input  logic signed [wbss_pkg::SampleW-1:0]  sample,
   output logic signed [wbss_pkg::SampleW-1:0]  result
);

   localparam int Q = wbss_pkg::QuoBits;

   // stage A: product
   logic signed [wbss_pkg::ProdW-1:0]   prod_ff;
   logic signed [wbss_pkg::SampleW-1:0] raw_ff;
   logic                                byp_ff;

   always_ff @(posedge clock) begin
      prod_ff <= wbss_pkg::ProdW'(sample) * wbss_pkg::ProdW'($signed({1'b0, gain}));
      raw_ff  <= sample;
      byp_ff  <= bypass;
   end

   // stage B: excess over knee, numerator, denominator, non-knee result
   logic                              knee;
   logic [32:0]                       u;
   logic signed [wbss_pkg::ProdW-1:0] rsum;
   wbss_pkg::div_beat_type            beat_b_in;
   wbss_pkg::div_beat_type            beat_b_ff;

   always_comb begin
      knee = !byp_ff && (prod_ff > $signed(wbss_pkg::ProdW'(wbss_pkg::KneeQ28)));
      u    = 33'(prod_ff - $signed(wbss_pkg::ProdW'(wbss_pkg::KneeQ28)));
      rsum = prod_ff + $signed(wbss_pkg::ProdW'(wbss_pkg::RoundHalf));
      // full-width numerator: head (25 bits) times excess (33 bits)
      beat_b_in.rem  = wbss_pkg::RemW'(u) * wbss_pkg::RemW'(wbss_pkg::HeadQ28);
      beat_b_in.den  = wbss_pkg::DenW'(wbss_pkg::HeadQ28) + {1'b0, u, 1'b0};
      beat_b_in.quo  = '0;
      beat_b_in.knee = knee;
      if (byp_ff)
         beat_b_in.early = raw_ff;
      else if (prod_ff <= 0)
         beat_b_in.early = '0;
      else
         beat_b_in.early = rsum[14 +: wbss_pkg::SampleW];
   end

   always_ff @(posedge clock) begin
      beat_b_ff <= beat_b_in;
   end

   // divider chain, one quotient bit per stage, MSB first
   wbss_pkg::div_beat_type chain [Q+1];
   assign chain[0] = beat_b_ff;

   for (genvar i = 0; i < Q; i++) begin : g_div
      wbss_div_stage u_stage (
         .clock    (clock),
         .sh       (wbss_pkg::ShW'(Q - 1 - i)),
         .beat_in  (chain[i]),
         .beat_out (chain[i+1])
      );
   end

   // final: knee + quotient, round half up; non-knee beats take the early result
   logic [31:0]                  ysum;
   logic [wbss_pkg::SampleW-1:0] res_in;
   logic [wbss_pkg::SampleW-1:0] res_ff;

   always_comb begin
      ysum = 32'(wbss_pkg::KneeQ28) + 32'(chain[Q].quo) + 32'(wbss_pkg::RoundHalf);
      res_in = chain[Q].knee ? ysum[14 +: wbss_pkg::SampleW] : chain[Q].early;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = $signed(res_ff);

endmodule
